// File: design/bpg_pkg.sv
`timescale 1ns / 1ps

package bpg_pkg;

  localparam int TIME_W     = 63;
  localparam int BUS_W      = 16;
  localparam int SHUNT_W    = 16;
  localparam int GAUGE_W    = 14;
  localparam int THR_W      = 18;
  localparam int MV_W       = 17;
  localparam int IVL_W      = 32;
  localparam int CELLS_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CURVE_POINTS = 12;
  localparam int CURVE_MV_W   = 13;
  localparam int CURVE_IDX_W  = $clog2(CURVE_POINTS);

  localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd3000, 13'd3450, 13'd3680, 13'd3740, 13'd3770, 13'd3790,
    13'd3820, 13'd3870, 13'd3920, 13'd3980, 13'd4060, 13'd4200
  };
  localparam logic [GAUGE_W-1:0] CURVE_BP [CURVE_POINTS] = '{
    14'd0,    14'd500,  14'd1000, 14'd2000, 14'd3000, 14'd4000,
    14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd10000
  };

  // shared divider: widest dividend is the interpolation product (450 * 500)
  localparam int DIVN_W    = 19;
  localparam int DIVD_W    = 13;
  localparam int DIV_CNT_W = $clog2(DIVN_W + 1);

  localparam logic [IVL_W-1:0]   RST_REFRESH_US = 32'd5000000;
  localparam logic [THR_W-1:0]   RST_THRESH_UV  = -18'sd200;
  localparam logic [MV_W-1:0]    RST_MIN_MV     = 17'd4000;
  localparam logic [MV_W-1:0]    RST_MAX_MV     = 17'd9500;
  localparam logic [CELLS_W-1:0] RST_CELLS      = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFRESH_INTERVAL = 3'd0,
    REG_CHARGE_THRESHOLD = 3'd1,
    REG_MIN_PACK         = 3'd2,
    REG_MAX_PACK         = 3'd3,
    REG_CELL_COUNT       = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PACK,
    S_CELL,
    S_SCAN,
    S_MUL,
    S_SEG,
    S_INTERP,
    S_EMIT
  } state_t;

endpackage

// File: design/bpg_req_if.sv
`timescale 1ns / 1ps

interface bpg_req_if;
  logic                              valid;
  logic                              ready;
  logic [bpg_pkg::TIME_W-1:0]        time_us;
  logic [bpg_pkg::BUS_W-1:0]         bus_code;
  logic signed [bpg_pkg::SHUNT_W-1:0] shunt_code;

  modport source (output valid, time_us, bus_code, shunt_code, input ready);
  modport sink   (input valid, time_us, bus_code, shunt_code, output ready);
endinterface

// File: design/bpg_rsp_if.sv
`timescale 1ns / 1ps

interface bpg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        reading_ok;
  logic [bpg_pkg::GAUGE_W-1:0] gauge_bp;
  logic                        is_charging;

  modport source (output valid, reading_ok, gauge_bp, is_charging, input ready);
  modport sink   (input valid, reading_ok, gauge_bp, is_charging, output ready);
endinterface

// File: design/bpg_cfg_if.sv
`timescale 1ns / 1ps

interface bpg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpg_pkg::CFG_IDX_W-1:0]  index;
  logic [bpg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/bpg_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bpg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bpg_pkg::DIVN_W-1:0]   dividend,
  input  logic [bpg_pkg::DIVD_W-1:0]   divisor,
  output logic                         done,
  output logic [bpg_pkg::DIVN_W-1:0]   quotient
);

  logic [bpg_pkg::DIVN_W-1:0]    quo;
  logic [bpg_pkg::DIVD_W-1:0]    rem;
  logic [bpg_pkg::DIVD_W-1:0]    dsr;
  logic [bpg_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic [bpg_pkg::DIVD_W:0]      shifted;
  logic [bpg_pkg::DIVD_W:0]      diff;
  logic                          ge;

  always_comb begin
    shifted = {rem, quo[bpg_pkg::DIVN_W-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = !diff[bpg_pkg::DIVD_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bpg_pkg::DIV_CNT_W'(bpg_pkg::DIVN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == bpg_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[bpg_pkg::DIVD_W-1:0] : shifted[bpg_pkg::DIVD_W-1:0];
      quo <= {quo[bpg_pkg::DIVN_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// File: design/battery_pack_gauge.sv
`timescale 1ns / 1ps

// channel  dir  payload                              transfer
// req      in   time_us, bus_code, shunt_code        valid & ready
// rsp      out  reading_ok, gauge_bp, is_charging    valid & ready
// cfg      in   index, data                          valid & ready (ready tied high)
//
// A request without a refresh goes from S_CHECK straight to S_EMIT.
// A refresh with the pack outside the window goes from S_PACK to S_EMIT. A valid pack runs
// the shared divider for the cell split and, when the cell voltage lies inside the curve,
// again for the interpolation, with a curve scan between.
// req.ready is high only while the sequencer is idle; a result still held in the
// output register stalls the sequencer in its last state until rsp.ready.
// Synchronous reset restores register defaults and clears the stored reading.
module battery_pack_gauge (
  input logic clk,
  input logic rst,
  bpg_req_if.sink   req,
  bpg_rsp_if.source rsp,
  bpg_cfg_if.sink   cfg
);

  bpg_pkg::state_t state, state_next;

  logic [bpg_pkg::IVL_W-1:0]   refresh_interval_us;
  logic signed [bpg_pkg::THR_W-1:0] charge_threshold_uv;
  logic [bpg_pkg::MV_W-1:0]    min_pack_mv;
  logic [bpg_pkg::MV_W-1:0]    max_pack_mv;
  logic [bpg_pkg::CELLS_W-1:0] cell_count;

  logic [bpg_pkg::TIME_W-1:0]  last_refresh_us;
  logic                        have_refreshed;
  logic                        stored_valid;
  logic [bpg_pkg::GAUGE_W-1:0] stored_gauge_bp;
  logic                        stored_charging;

  logic [bpg_pkg::TIME_W-1:0]  req_time;
  logic [bpg_pkg::BUS_W-1:0]   req_bus;
  logic signed [bpg_pkg::SHUNT_W-1:0] req_shunt;
  logic                        chg_flag;
  logic [bpg_pkg::MV_W-1:0]    cell_mv;
  logic [bpg_pkg::CURVE_IDX_W-1:0] scan_idx;
  logic [bpg_pkg::CURVE_MV_W-1:0]  seg_d;
  logic [bpg_pkg::DIVN_W-1:0]  prod;

  logic                        res_valid;
  logic                        res_ok;
  logic [bpg_pkg::GAUGE_W-1:0] res_gauge;
  logic                        res_chg;

  logic                        div_start;
  logic [bpg_pkg::DIVN_W-1:0]  div_a;
  logic [bpg_pkg::DIVD_W-1:0]  div_b;
  logic                        div_done;
  logic [bpg_pkg::DIVN_W-1:0]  div_q;

  logic [bpg_pkg::TIME_W-1:0]  elapsed;
  logic                        refresh;
  logic signed [18:0]          shunt_x5;
  logic signed [18:0]          shunt_microvolts;
  logic                        chg_now;
  logic [bpg_pkg::BUS_W+2:0]   bus_x5;
  logic [bpg_pkg::MV_W-1:0]    pack_mv;
  logic                        pack_ok;
  logic [bpg_pkg::CELLS_W-1:0] cells;
  logic [bpg_pkg::MV_W-1:0]    div_mv;
  logic [bpg_pkg::CURVE_IDX_W-1:0] prev_idx;
  logic [bpg_pkg::CURVE_MV_W-1:0]  mv_hi;
  logic [bpg_pkg::CURVE_MV_W-1:0]  mv_lo;
  logic [bpg_pkg::CURVE_MV_W-1:0]  seg_dx;
  logic [bpg_pkg::GAUGE_W-1:0]     seg_dy;
  logic                        scan_hit;
  logic                        can_emit;

  bpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    elapsed  = req_time - last_refresh_us;
    refresh  = !have_refreshed ||
               (req_time > last_refresh_us &&
                elapsed > bpg_pkg::TIME_W'(refresh_interval_us));
    shunt_x5 = (19'(req_shunt) <<< 2) + 19'(req_shunt);
    shunt_microvolts = (shunt_x5 + $signed({18'd0, shunt_x5[18]})) >>> 1;
    chg_now  = shunt_microvolts < 19'(charge_threshold_uv);
    // 125 / 100 is 5 / 4
    bus_x5   = {3'b000, req_bus} + {1'b0, req_bus, 2'b00};
    pack_mv  = bus_x5[bpg_pkg::BUS_W+2:2];
    pack_ok  = pack_mv > min_pack_mv && pack_mv < max_pack_mv;
    cells    = (cell_count == '0) ? bpg_pkg::CELLS_W'(1) : cell_count;
    div_mv   = div_q[bpg_pkg::MV_W-1:0];
    prev_idx = scan_idx - 1'b1;
    mv_hi    = bpg_pkg::CURVE_MV[scan_idx];
    mv_lo    = bpg_pkg::CURVE_MV[prev_idx];
    seg_dx   = mv_hi - mv_lo;
    seg_dy   = bpg_pkg::CURVE_BP[scan_idx] - bpg_pkg::CURVE_BP[prev_idx];
    scan_hit = cell_mv <= bpg_pkg::MV_W'(mv_hi);
    can_emit = !res_valid || rsp.ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      bpg_pkg::S_IDLE:   if (req.valid) state_next = bpg_pkg::S_CHECK;
      bpg_pkg::S_CHECK:  state_next = refresh ? bpg_pkg::S_PACK : bpg_pkg::S_EMIT;
      bpg_pkg::S_PACK:   state_next = pack_ok ? bpg_pkg::S_CELL : bpg_pkg::S_EMIT;
      bpg_pkg::S_CELL: begin
        if (div_done) begin
          state_next = (div_mv <= bpg_pkg::MV_W'(bpg_pkg::CURVE_MV[0])) ?
                       bpg_pkg::S_EMIT : bpg_pkg::S_SCAN;
        end
      end
      bpg_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_next = bpg_pkg::S_MUL;
        end else if (scan_idx == bpg_pkg::CURVE_IDX_W'(bpg_pkg::CURVE_POINTS - 1)) begin
          state_next = bpg_pkg::S_EMIT;
        end
      end
      bpg_pkg::S_MUL:    state_next = bpg_pkg::S_SEG;
      bpg_pkg::S_SEG:    state_next = (seg_dx == '0) ? bpg_pkg::S_EMIT : bpg_pkg::S_INTERP;
      bpg_pkg::S_INTERP: if (div_done) state_next = bpg_pkg::S_EMIT;
      bpg_pkg::S_EMIT:   if (can_emit) state_next = bpg_pkg::S_IDLE;
      default:           state_next = bpg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state)
      bpg_pkg::S_IDLE: req.ready = 1'b1;
      bpg_pkg::S_PACK: begin
        div_start = pack_ok;
        div_a     = bpg_pkg::DIVN_W'(pack_mv);
        div_b     = bpg_pkg::DIVD_W'(cells);
      end
      bpg_pkg::S_SEG: begin
        div_start = seg_dx != '0;
        div_a     = prod;
        div_b     = bpg_pkg::DIVD_W'(seg_dx);
      end
      default: ;
    endcase
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= bpg_pkg::S_IDLE;
      refresh_interval_us <= bpg_pkg::RST_REFRESH_US;
      charge_threshold_uv <= bpg_pkg::RST_THRESH_UV;
      min_pack_mv         <= bpg_pkg::RST_MIN_MV;
      max_pack_mv         <= bpg_pkg::RST_MAX_MV;
      cell_count          <= bpg_pkg::RST_CELLS;
      last_refresh_us     <= '0;
      have_refreshed      <= 1'b0;
      stored_valid        <= 1'b0;
      stored_gauge_bp     <= '0;
      stored_charging     <= 1'b0;
      res_valid           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          bpg_pkg::REG_REFRESH_INTERVAL: refresh_interval_us <= cfg.data;
          bpg_pkg::REG_CHARGE_THRESHOLD: charge_threshold_uv <= cfg.data[bpg_pkg::THR_W-1:0];
          bpg_pkg::REG_MIN_PACK:         min_pack_mv <= cfg.data[bpg_pkg::MV_W-1:0];
          bpg_pkg::REG_MAX_PACK:         max_pack_mv <= cfg.data[bpg_pkg::MV_W-1:0];
          bpg_pkg::REG_CELL_COUNT:       cell_count <= cfg.data[bpg_pkg::CELLS_W-1:0];
          default: ;
        endcase
      end
      if (state == bpg_pkg::S_EMIT && can_emit) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        bpg_pkg::S_CHECK: begin
          if (refresh) begin
            have_refreshed  <= 1'b1;
            last_refresh_us <= req_time;
          end
        end
        bpg_pkg::S_PACK: begin
          stored_valid    <= pack_ok;
          stored_charging <= pack_ok && chg_flag;
          stored_gauge_bp <= '0;
        end
        bpg_pkg::S_SCAN: begin
          if (!scan_hit &&
              scan_idx == bpg_pkg::CURVE_IDX_W'(bpg_pkg::CURVE_POINTS - 1)) begin
            stored_gauge_bp <= bpg_pkg::CURVE_BP[bpg_pkg::CURVE_POINTS-1];
          end
        end
        bpg_pkg::S_SEG: begin
          if (seg_dx == '0) stored_gauge_bp <= bpg_pkg::CURVE_BP[prev_idx];
        end
        bpg_pkg::S_INTERP: begin
          if (div_done) begin
            stored_gauge_bp <= bpg_pkg::CURVE_BP[prev_idx] + div_q[bpg_pkg::GAUGE_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == bpg_pkg::S_IDLE && req.valid) begin
      req_time  <= req.time_us;
      req_bus   <= req.bus_code;
      req_shunt <= req.shunt_code;
    end
    if (state == bpg_pkg::S_CHECK) chg_flag <= chg_now;
    if (state == bpg_pkg::S_CELL && div_done) begin
      cell_mv  <= div_mv;
      scan_idx <= bpg_pkg::CURVE_IDX_W'(1);
    end
    if (state == bpg_pkg::S_SCAN) begin
      if (scan_hit) begin
        seg_d <= cell_mv[bpg_pkg::CURVE_MV_W-1:0] - mv_lo;
      end else if (scan_idx != bpg_pkg::CURVE_IDX_W'(bpg_pkg::CURVE_POINTS - 1)) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (state == bpg_pkg::S_MUL) begin
      prod <= bpg_pkg::DIVN_W'(seg_d) * bpg_pkg::DIVN_W'(seg_dy);
    end
    if (state == bpg_pkg::S_EMIT && can_emit) begin
      res_ok    <= stored_valid;
      res_gauge <= stored_valid ? stored_gauge_bp : '0;
      res_chg   <= stored_valid && stored_charging;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.reading_ok  = res_ok;
  assign rsp.gauge_bp    = res_gauge;
  assign rsp.is_charging = res_chg;

endmodule
